### hdl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg - shared types and constants for the multi-channel watchdog
// Command and status codes, beat packing and the token that runs along the
// cell chain.
// ----------------------------------------------------------------------------
package mcw_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int TICK_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam int IN_BITS  = CMD_W + SLOT_W + TICK_W + TICK_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + 1 + SLOT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADVANCE    = 3'd0,
        CMD_REGISTER   = 3'd1,
        CMD_UNREGISTER = 3'd2,
        CMD_RELOAD     = 3'd3,
        CMD_CHECK      = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] timeout;
        logic [TICK_W-1:0] tick;
        status_t           status;
        logic              found;
        logic [SLOT_W-1:0] which;
    } tok_t;

endpackage

### hdl/multi_channel_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_watchdog - slot-table watchdog with command stream
// Tick counter feeding a chain of slot cells; one result beat per command.
// ----------------------------------------------------------------------------
// Every command beat runs along a chain of NUM_SLOTS cells, each of which
// registers the token, so its result beat leaves the last cell's register;
// the chain is fully pipelined and takes one command per cycle. A stalled
// output holds the whole chain and drops s_axis_tready. Check reports the
// lowest-indexed expired active slot; unused slots are never read.
module multi_channel_watchdog
    import mcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[2:0], slot[5:3], tick_amount[37:6], timeout_value[69:38], zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[1:0], expired_found[2], expired_slot[5:3], zero pad
    output logic [OUT_W-1:0] m_axis_tdata
);

    tok_t chain [NUM_SLOTS+1];
    logic adv;
    logic accept;

    assign adv           = !chain[NUM_SLOTS].valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    mcw_head u_head (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .beat_valid (s_axis_tvalid),
        .beat_data  (s_axis_tdata),
        .tok_out    (chain[0])
    );

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        mcw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_idx (IDX_W'(i)),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign m_axis_tvalid = chain[NUM_SLOTS].valid;
    assign m_axis_tdata  = OUT_W'({chain[NUM_SLOTS].which,
                                   chain[NUM_SLOTS].found,
                                   chain[NUM_SLOTS].status});

endmodule

### hdl/mcw_head.sv
// ----------------------------------------------------------------------------
// mcw_head - tick counter and command decode
// Holds the tick count, which only ADVANCE commands move on, and turns an
// input beat into a token for the first cell.
// ----------------------------------------------------------------------------
module mcw_head
    import mcw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            beat_valid,
    input  logic [IN_W-1:0] beat_data,
    output tok_t            tok_out
);

    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    cmd_t              cmd;
    logic [TICK_W-1:0] amount;

    assign cmd    = cmd_t'(beat_data[CMD_W-1:0]);
    assign amount = beat_data[CMD_W+SLOT_W+TICK_W-1:CMD_W+SLOT_W];

    always_comb
    begin
        tick_next = tick_reg;
        if (accept && (cmd == CMD_ADVANCE))
        begin
            tick_next = tick_reg + amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
        end
    end

    always_comb
    begin
        tok_out.valid   = beat_valid;
        tok_out.cmd     = cmd;
        tok_out.slot    = beat_data[CMD_W+SLOT_W-1:CMD_W];
        tok_out.timeout = beat_data[IN_BITS-1:CMD_W+SLOT_W+TICK_W];
        tok_out.tick    = tick_reg;
        tok_out.found   = 1'b0;
        tok_out.which   = '0;
        unique case (cmd)
            CMD_REGISTER, CMD_UNREGISTER, CMD_RELOAD: tok_out.status = ST_IGNORED;
            default:                                  tok_out.status = ST_DONE;
        endcase
    end

endmodule

### hdl/mcw_cell.sv
// ----------------------------------------------------------------------------
// mcw_cell - one watchdog slot
// Holds a slot's state, acts on the token passing through and hands it on
// to the next cell.
// ----------------------------------------------------------------------------
module mcw_cell
    import mcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [IDX_W-1:0] cell_idx,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic              active_reg;
    logic              active_next;
    logic [TICK_W-1:0] kick_reg;
    logic [TICK_W-1:0] kick_next;
    logic [TICK_W-1:0] tmo_reg;
    logic [TICK_W-1:0] tmo_next;
    logic              valid_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [CMP_W-1:0]  idx_ext;
    logic              hit;
    logic [TICK_W-1:0] age;
    logic              expired;

    assign idx_ext = CMP_W'(cell_idx);
    assign hit     = tok_in.valid && (CMP_W'(tok_in.slot) == idx_ext);
    assign age     = tok_in.tick - kick_reg;
    assign expired = age > tmo_reg;

    always_comb
    begin
        tok_next    = tok_in;
        active_next = active_reg;
        kick_next   = kick_reg;
        tmo_next    = tmo_reg;
        unique case (tok_in.cmd)
            CMD_REGISTER:
            begin
                if (hit && !active_reg)
                begin
                    tok_next.status = ST_DONE;
                    active_next     = 1'b1;
                    kick_next       = tok_in.tick;
                    tmo_next        = tok_in.timeout;
                end
            end
            CMD_UNREGISTER:
            begin
                if (hit && active_reg)
                begin
                    tok_next.status = ST_DONE;
                    active_next     = 1'b0;
                end
            end
            CMD_RELOAD:
            begin
                if (hit && active_reg)
                begin
                    if (expired)
                    begin
                        tok_next.status = ST_REFUSED;
                    end
                    else
                    begin
                        tok_next.status = ST_DONE;
                        kick_next       = tok_in.tick;
                    end
                end
            end
            CMD_CHECK:
            begin
                if (tok_in.valid && !tok_in.found && active_reg && expired)
                begin
                    tok_next.found = 1'b1;
                    tok_next.which = idx_ext[SLOT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            active_reg <= active_next;
            valid_reg  <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kick_reg <= kick_next;
            tmo_reg  <= tmo_next;
            tok_reg  <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

### hdl/mcw_checker.sv
// ----------------------------------------------------------------------------
// mcw_checker - port-level checks for the multi-channel watchdog
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module mcw_checker
    import mcw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[5:3] == 3'd0)
        else $error("slot index given without expiry");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0)
        else $error("expiry reported with non-done status");

endmodule

bind multi_channel_watchdog mcw_checker u_mcw_checker (.*);
